// ===== src/assert_macros.svh =====
// assertion helpers included by the draw engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MFDE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define MFDE_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define MFDE_ASSERT(lbl, clk, rstn, prop)
`define MFDE_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== src/mfde_pkg.sv =====
// ----------------------------------------------------------------------------
// mfde_pkg
// shared constants and codes of the frame buffer draw engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mfde_pkg;
  localparam int Width       = 128;
  localparam int Height      = 72;
  localparam int StoreBytes  = Width * ((Height + 7) / 8);
  localparam int AddrW       = $clog2(StoreBytes);
  localparam int AccW        = 26;
  localparam int QuoW        = 17;

  typedef enum logic [3:0] {
    OP_PIXEL    = 4'd0,
    OP_INVERT   = 4'd1,
    OP_HLINE    = 4'd2,
    OP_VLINE    = 4'd3,
    OP_LINE     = 4'd4,
    OP_FILLRECT = 4'd5,
    OP_RECT     = 4'd6,
    OP_CLEAR    = 4'd7,
    OP_FILL     = 4'd8,
    OP_READ     = 4'd9
  } opcode_e;
endpackage
`default_nettype wire

// ===== src/mfde_div.sv =====
// ----------------------------------------------------------------------------
// mfde_div
// restoring divider, one quotient bit per cycle, for (num * 65536) / den
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mfde_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [7:0]                num_i,
  input  wire logic [7:0]                den_i,
  output logic                           done_o,
  output logic [mfde_pkg::QuoW-1:0]      quo_o
);
  logic [23:0] dv_q;
  logic [7:0]  rem_q;
  logic [7:0]  den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [mfde_pkg::QuoW-1:0] quo_q;
  logic [8:0]  trial;
  logic        fits;

  assign trial = {rem_q, dv_q[23]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd23;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= {num_i, 16'd0};
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      dv_q  <= {dv_q[22:0], 1'b0};
      rem_q <= fits ? 8'(trial - {1'b0, den_q}) : trial[7:0];
      quo_q <= {quo_q[mfde_pkg::QuoW-2:0], fits};
    end
  end

  assign quo_o = quo_q;
endmodule
`default_nettype wire

// ===== src/monochrome_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// monochrome_framebuffer_draw_engine
// drawing engine over a page-organized 1-bit frame buffer
// ----------------------------------------------------------------------------
// One command item in, one result item out. Drawing commands walk pixels
// through a single cursor/accumulator datapath and RAM read-modify-write:
// on-screen pixels pass S_PLOT and S_WR, off-screen ones S_PLOT only,
// and each span adds S_LOAD, a last S_PLOT and S_END. A sloped line also
// waits in S_DIV for the bit-serial slope divider. Clear and fill sweep
// all 1152 bytes at one byte a cycle; read passes S_READ and S_READW.
// After reset the same sweep clears the buffer, and no item is accepted
// until it ends. Only one command is in flight; the result register lets
// the next command be accepted while the previous result still waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module monochrome_framebuffer_draw_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_wdata_i,   // flip_horizontal
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // opcode[3:0] x_a[11:4] y_a[19:12] x_b[27:20] y_b[35:28] length[43:36]
  // pen[44] read_index[55:45]
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o   // read_data[7:0]
);
  localparam int AW = mfde_pkg::AddrW;
  localparam int CW = mfde_pkg::AccW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOAD, S_DIV, S_PLOT, S_WR, S_END, S_READ, S_READW, S_DONE
  } state_e;

  state_e state_q;
  logic   flip_q;

  // command registers
  logic [3:0]    op_q;
  logic [7:0]    ax_q, ay_q, bx_q, by_q, len_q, row_q;
  logic          pen_q;
  logic [10:0]   ridx_q;
  logic [1:0]    seg_q;
  logic [7:0]    res_q;
  logic [7:0]    out_data_q;

  // span cursor
  logic          xmaj_q, neg_q;
  logic [9:0]    maj_q;
  logic [8:0]    cnt_q;
  logic signed [CW-1:0] acc_q, inc_q;

  logic [AW-1:0] clr_q, addr_q;
  logic [7:0]    fillv_q, mask_q;

  // memory
  logic [7:0]    mem_q [mfde_pkg::StoreBytes];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[mem_ra];
  end

  // field unpack and line endpoint ordering
  logic [3:0] in_op;
  logic [7:0] in_xa, in_ya, in_xb, in_yb;
  logic [7:0] s1xa, s1ya, s1xb, s1yb, lxa, lya, lxb, lyb;
  assign in_op = s_axis_tdata_i[3:0];
  assign in_xa = s_axis_tdata_i[11:4];
  assign in_ya = s_axis_tdata_i[19:12];
  assign in_xb = s_axis_tdata_i[27:20];
  assign in_yb = s_axis_tdata_i[35:28];

  always_comb begin
    s1xa = in_xa; s1ya = in_ya; s1xb = in_xb; s1yb = in_yb;
    if (in_xb < in_xa) begin
      s1xa = in_xb; s1ya = in_yb; s1xb = in_xa; s1yb = in_ya;
    end
    lxa = s1xa; lya = s1ya; lxb = s1xb; lyb = s1yb;
    if (s1yb < s1ya) begin
      lxa = s1xb; lya = s1yb; lxb = s1xa; lyb = s1ya;
    end
  end

  // clamped rectangle maxima
  logic [7:0] cxb, cyb;
  assign cxb = (in_xb > 8'(mfde_pkg::Width - 1))  ? 8'(mfde_pkg::Width - 1)  : in_xb;
  assign cyb = (in_yb > 8'(mfde_pkg::Height - 1)) ? 8'(mfde_pkg::Height - 1) : in_yb;

  // line geometry from the ordered endpoints
  logic signed [8:0] ldx;
  logic [7:0] adx, ady;
  logic       xmajor;
  assign ldx    = $signed({1'b0, bx_q}) - $signed({1'b0, ax_q});
  assign adx    = ldx[8] ? 8'(-ldx) : ldx[7:0];
  assign ady    = by_q - ay_q;
  assign xmajor = adx > ady;

  // slope divider
  logic div_start, div_done;
  logic [mfde_pkg::QuoW-1:0] div_quo;
  mfde_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (xmajor ? ady : adx),
    .den_i   (xmajor ? adx : ady),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // pixel from cursor: round minor as floor(acc + half)
  logic signed [CW-1:0] rsum;
  logic [9:0] minor, px, py, col;
  logic       on_screen;
  logic [AW-1:0] pix_addr;
  assign rsum  = acc_q + CW'(32768);
  assign minor = {1'b0, rsum[24:16]};
  assign px    = xmaj_q ? maj_q : minor;
  assign py    = xmaj_q ? minor : maj_q;
  assign on_screen = !rsum[CW-1] && (px < 10'(mfde_pkg::Width))
                     && (py < 10'(mfde_pkg::Height));
  assign col = flip_q ? 10'(mfde_pkg::Width - 1) - px : px;
  assign pix_addr = AW'(py[9:3]) * AW'(mfde_pkg::Width) + AW'(col);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = rdata_q;
    mem_ra = pix_addr;
    if (state_q == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = fillv_q;
    end else if (state_q == S_WR) begin
      mem_we = 1'b1;
      if (op_q == mfde_pkg::OP_INVERT) mem_wd = rdata_q ^ mask_q;
      else if (pen_q)                  mem_wd = rdata_q | mask_q;
      else                             mem_wd = rdata_q & ~mask_q;
    end
    if (state_q == S_READ) mem_ra = ridx_q[AW-1:0];
  end

  assign div_start = (state_q == S_LOAD) && (op_q == mfde_pkg::OP_LINE)
                     && (ay_q != by_q) && (ax_q != bx_q);
  assign s_axis_tready_o = (state_q == S_IDLE);

  // result register can take a new item
  logic out_free;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  // marks that the clear sweep belongs to a command rather than to reset
  logic cmd_seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                                     cmd_seen_q <= 1'b0;
    else if (state_q == S_IDLE && s_axis_tvalid_i)   cmd_seen_q <= 1'b1;
  end

  // span loader helpers
  function automatic logic [8:0] span_cnt(input logic [7:0] lo, input logic [7:0] hi);
    span_cnt = (hi >= lo) ? 9'({1'b0, hi} - {1'b0, lo} + 9'd1) : 9'd0;
  endfunction
  function automatic logic signed [CW-1:0] to_acc(input logic [7:0] v);
    to_acc = {2'b00, v, 16'd0};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLR;
      flip_q          <= 1'b0;
      clr_q           <= '0;
      fillv_q         <= 8'h00;
      m_axis_tvalid_o <= 1'b0;
      out_data_q      <= 8'h00;
    end else begin
      if (cfg_we_i) flip_q <= cfg_wdata_i[0];
      // result side: load the finished item or drop the accepted one
      if (state_q == S_DONE && out_free) begin
        m_axis_tvalid_o <= 1'b1;
        out_data_q      <= res_q;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        m_axis_tvalid_o <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          if (clr_q == AW'(mfde_pkg::StoreBytes - 1)) begin
            clr_q   <= '0;
            // the sweep after reset ends without an item
            state_q <= cmd_seen_q ? S_DONE : S_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q   <= in_op;
            len_q  <= s_axis_tdata_i[43:36];
            pen_q  <= s_axis_tdata_i[44];
            ridx_q <= s_axis_tdata_i[55:45];
            seg_q  <= '0;
            res_q  <= 8'd0;
            row_q  <= in_ya;
            if (in_op == mfde_pkg::OP_LINE) begin
              ax_q <= lxa; ay_q <= lya; bx_q <= lxb; by_q <= lyb;
            end else begin
              ax_q <= in_xa; ay_q <= in_ya; bx_q <= cxb; by_q <= cyb;
            end
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          neg_q <= 1'b0;
          inc_q <= '0;
          unique case (op_q)
            mfde_pkg::OP_PIXEL, mfde_pkg::OP_INVERT: begin
              xmaj_q <= 1'b1; state_q <= S_PLOT;
              maj_q <= {2'b00, ax_q}; cnt_q <= 9'd1; acc_q <= to_acc(ay_q);
            end
            mfde_pkg::OP_HLINE: begin
              xmaj_q <= 1'b1; state_q <= S_PLOT;
              maj_q <= {2'b00, ax_q}; cnt_q <= {1'b0, len_q}; acc_q <= to_acc(ay_q);
            end
            mfde_pkg::OP_VLINE: begin
              xmaj_q <= 1'b0; state_q <= S_PLOT;
              maj_q <= {2'b00, ay_q}; cnt_q <= {1'b0, len_q}; acc_q <= to_acc(ax_q);
            end
            mfde_pkg::OP_LINE: begin
              if (ay_q == by_q) begin
                xmaj_q <= 1'b1; state_q <= S_PLOT;
                maj_q <= {2'b00, ax_q}; cnt_q <= span_cnt(ax_q, bx_q);
                acc_q <= to_acc(ay_q);
              end else if (ax_q == bx_q) begin
                xmaj_q <= 1'b0; state_q <= S_PLOT;
                maj_q <= {2'b00, ay_q}; cnt_q <= span_cnt(ay_q, by_q);
                acc_q <= to_acc(ax_q);
              end else begin
                state_q <= S_DIV;
              end
            end
            mfde_pkg::OP_FILLRECT: begin
              xmaj_q  <= 1'b1;
              state_q <= (row_q > by_q) ? S_DONE : S_PLOT;
              maj_q <= {2'b00, ax_q}; cnt_q <= span_cnt(ax_q, bx_q);
              acc_q <= to_acc(row_q);
            end
            mfde_pkg::OP_RECT: begin
              state_q <= S_PLOT;
              if (seg_q[1]) begin
                xmaj_q <= 1'b0;
                maj_q  <= {2'b00, ay_q}; cnt_q <= span_cnt(ay_q, by_q);
                acc_q  <= to_acc(seg_q[0] ? bx_q : ax_q);
              end else begin
                xmaj_q <= 1'b1;
                maj_q <= {2'b00, ax_q}; cnt_q <= span_cnt(ax_q, bx_q);
                acc_q <= to_acc(seg_q[0] ? by_q : ay_q);
              end
            end
            mfde_pkg::OP_CLEAR: begin
              fillv_q <= 8'h00; state_q <= S_CLR;
            end
            mfde_pkg::OP_FILL: begin
              fillv_q <= 8'hFF; state_q <= S_CLR;
            end
            mfde_pkg::OP_READ: begin
              state_q <= (ridx_q < 11'(mfde_pkg::StoreBytes)) ? S_READ : S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_PLOT;
            if (xmajor) begin
              xmaj_q <= 1'b1;
              maj_q  <= {2'b00, ax_q};
              neg_q  <= ldx[8];
              acc_q  <= to_acc(ay_q);
              inc_q  <= CW'(div_quo);
              cnt_q  <= {1'b0, adx} + 9'd1;
            end else begin
              xmaj_q <= 1'b0;
              maj_q  <= {2'b00, ay_q};
              neg_q  <= 1'b0;
              acc_q  <= to_acc(ax_q);
              inc_q  <= ldx[8] ? -CW'(div_quo) : CW'(div_quo);
              cnt_q  <= {1'b0, ady} + 9'd1;
            end
          end
        end
        S_PLOT: begin
          if (cnt_q == 9'd0) begin
            state_q <= S_END;
          end else begin
            cnt_q  <= cnt_q - 9'd1;
            acc_q  <= acc_q + inc_q;
            maj_q  <= neg_q ? maj_q - 10'd1 : maj_q + 10'd1;
            addr_q <= pix_addr;
            mask_q <= 8'(1) << py[2:0];
            if (on_screen) state_q <= S_WR;
          end
        end
        S_WR: state_q <= S_PLOT;
        S_END: begin
          if (op_q == mfde_pkg::OP_FILLRECT && row_q < by_q) begin
            row_q   <= row_q + 8'd1;
            state_q <= S_LOAD;
          end else if (op_q == mfde_pkg::OP_RECT && seg_q != 2'd3) begin
            seg_q   <= seg_q + 2'd1;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_READ:  state_q <= S_READW;
        S_READW: begin
          res_q   <= rdata_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata_o = out_data_q;

  `MFDE_ASSERT(a_wr_after_plot, clk_i, rst_ni, state_q == S_WR |-> $past(state_q) == S_PLOT)
  `MFDE_NEVER(a_div_done_idle, clk_i, rst_ni, div_done && state_q != S_DIV)
  `MFDE_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(state_q) == S_DONE)
endmodule
`default_nettype wire
